>>> src/wwr_pkg.sv
// shared types, constants and helpers for the whole-word replace block
package wwr_pkg;

    localparam int WORD_CAP   = 8;
    localparam int IDX_W      = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
    localparam int CNT_W      = 4;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int REPL_MAX   = 8;
    localparam logic [7:0] DELIM_CHAR = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_CASE   = 3'd0,
        CFG_TARGET_WORD  = 3'd1,
        CFG_TARGET_LEN   = 3'd2,
        CFG_REPLACE_WORD = 3'd3,
        CFG_REPLACE_LEN  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic plan;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic plan_emits;
        logic item_final;
    } status_t;

    // ascii lowercase fold
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'd65:8'd90]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

>>> src/whole_word_replace.sv
// top level of the streaming whole-word find and replace block
//
// input stream: one text byte per item in s_tdata[7:0], s_tlast marks the
// last byte of a string. byte 32 (space) splits words. every word, the empty
// word between two spaces too, is compared with target_word (exact, or ascii
// case-insensitive when match_case is 0) and replaced by replace_word on a
// match. a space that ends the string is dropped. words are buffered up to
// eight bytes; a longer word is flushed unchanged and passes straight through.
// output stream: zero to nine result items per input item. m_tuser[0] is
// has_byte (0 only on the end marker of an empty result), m_tuser[1] marks the
// last result of the input item, m_tlast the final result of the string.
// an item is taken in ST_IDLE and planned in ST_PLAN, then its results are
// loaded one by one into the single shared output register in ST_EMIT.
// s_tready is high only between items. when the receiver stalls, the output
// register holds and the next result waits; a new item can be taken while the
// last result of the previous one still sits in the output register.
// reset (aresetn low, synchronous) empties the word buffer, clears the output
// valid and sets match_case to 1 and the other config registers to 0.
module whole_word_replace (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [wwr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wwr_pkg::CFG_W-1:0]     cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // in_byte
    input  logic                          s_tlast,   // in_last
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic [1:0]                    m_tuser,   // has_byte, run_last
    output logic                          m_tlast    // out_last
);
    import wwr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    has_byte, run_last;

    // sequencing and output handshake
    wwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // buffer, compare and result selection
    wwr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_byte      (s_tdata),
        .s_last      (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_byte      (m_tdata),
        .m_has_byte  (has_byte),
        .m_run_last  (run_last),
        .m_out_last  (m_tlast)
    );

    assign m_tuser = {run_last, has_byte};

    // one item at a time: after taking an item, ready drops for the plan cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous one still in planning");

    // the end of the string is always the end of the run
    a_last_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("string end without run end");

    // an end marker is alone, final and carries a zero byte
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata == 8'd0))
        else $error("malformed end marker");

    // no result is shown while the block waits for a new item with nothing to send
    a_emit_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tready |=> !m_tvalid)
        else $error("result appeared without an item");

endmodule

>>> src/wwr_ctrl.sv
// controller: item sequencing and output valid handshake
module wwr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  wwr_pkg::status_t  status,
    output wwr_pkg::cmd_t     cmd
);
    import wwr_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PLAN;
                end
            end
            ST_PLAN: begin
                cmd.plan   = 1'b1;
                state_next = status.plan_emits ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // load when the output register is empty or being drained
                if (!m_valid_reg || m_tready) begin
                    cmd.load = 1'b1;
                    if (status.item_final) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

>>> src/wwr_datapath.sv
// datapath: config registers, word buffer, match compare and result sequencing
module wwr_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [wwr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wwr_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [7:0]                   s_byte,
    input  logic                         s_last,
    input  wwr_pkg::cmd_t                cmd,
    output wwr_pkg::status_t             status,
    output logic [7:0]                   m_byte,
    output logic                         m_has_byte,
    output logic                         m_run_last,
    output logic                         m_out_last
);
    import wwr_pkg::*;

    // configuration
    logic                match_case_reg;
    logic [CFG_W-1:0]    target_word_reg;
    logic [CNT_W-1:0]    target_len_reg;
    logic [CFG_W-1:0]    replace_word_reg;
    logic [CNT_W-1:0]    replace_len_reg;

    // word buffer state
    logic [7:0]          word_store_reg [WORD_CAP];
    logic [CNT_W-1:0]    word_count_reg, word_count_next;
    logic                overflowed_reg, overflowed_next;

    // captured item and emit plan
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                src_repl_reg, src_repl_next;
    logic [CNT_W-1:0]    src_n_reg, src_n_next;
    logic                marker_reg, marker_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    idx_reg;

    // output register
    logic [7:0]          m_byte_reg, m_byte_next;
    logic                m_has_reg, m_has_next;
    logic                m_run_last_reg, m_run_last_next;
    logic                m_out_last_reg, m_out_last_next;

    logic [7:0]          view [WORD_CAP];
    logic [CNT_W-1:0]    wcnt;
    logic                is_delim, store_we, flush, dump, tail, match;
    logic [CNT_W-1:0]    repl_n;
    logic [7:0]          tb, wb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_case_reg   <= 1'b1;
            target_word_reg  <= '0;
            target_len_reg   <= '0;
            replace_word_reg <= '0;
            replace_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MATCH_CASE:   match_case_reg   <= cfg_wr_data[0];
                CFG_TARGET_WORD:  target_word_reg  <= cfg_wr_data;
                CFG_TARGET_LEN:   target_len_reg   <= cfg_wr_data[CNT_W-1:0];
                CFG_REPLACE_WORD: replace_word_reg <= cfg_wr_data;
                CFG_REPLACE_LEN:  replace_len_reg  <= cfg_wr_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // plan: update buffer state and decide what this item emits
    always_comb begin
        is_delim        = (in_byte_reg == DELIM_CHAR);
        view            = word_store_reg;
        wcnt            = word_count_reg;
        store_we        = 1'b0;
        flush           = 1'b0;
        dump            = 1'b0;
        tail            = 1'b0;
        word_count_next = word_count_reg;
        overflowed_next = overflowed_reg;
        if (is_delim) begin
            flush           = !overflowed_reg;
            tail            = !in_last_reg;
            word_count_next = '0;
            overflowed_next = 1'b0;
        end else if (overflowed_reg) begin
            tail = 1'b1;
        end else if (word_count_reg < CNT_W'(WORD_CAP)) begin
            store_we                          = 1'b1;
            view[word_count_reg[IDX_W-1:0]]   = in_byte_reg;
            wcnt                              = word_count_reg + 1'b1;
            word_count_next                   = word_count_reg + 1'b1;
            flush                             = in_last_reg;
        end else begin
            // long word: flush buffer unchanged, then pass the rest through
            dump            = 1'b1;
            tail            = 1'b1;
            word_count_next = '0;
            overflowed_next = 1'b1;
        end
        if (!is_delim && in_last_reg) begin
            word_count_next = '0;
            overflowed_next = 1'b0;
        end

        match = (target_len_reg == wcnt);
        for (int i = 0; i < WORD_CAP; i++) begin
            tb = target_word_reg[8*i +: 8];
            wb = view[i];
            if (!match_case_reg) begin
                tb = fold(tb);
                wb = fold(wb);
            end
            if ((CNT_W'(i) < wcnt) && (tb != wb)) begin
                match = 1'b0;
            end
        end

        repl_n = (replace_len_reg > CNT_W'(REPL_MAX)) ? CNT_W'(REPL_MAX) : replace_len_reg;
        src_repl_next = 1'b0;
        if (flush && match) begin
            src_repl_next = 1'b1;
            src_n_next    = repl_n;
        end else if (flush) begin
            src_n_next = wcnt;
        end else if (dump) begin
            src_n_next = word_count_reg;
        end else begin
            src_n_next = '0;
        end
        total_next  = src_n_next + CNT_W'(tail);
        marker_next = in_last_reg && (total_next == '0);
        if (marker_next) begin
            total_next = CNT_W'(1);
        end
    end

    // current result item
    always_comb begin
        if (marker_reg) begin
            m_byte_next = '0;
            m_has_next  = 1'b0;
        end else if (idx_reg < src_n_reg) begin
            m_has_next  = 1'b1;
            m_byte_next = src_repl_reg ? replace_word_reg[{idx_reg[2:0], 3'b000} +: 8]
                                       : word_store_reg[idx_reg[IDX_W-1:0]];
        end else begin
            m_has_next  = 1'b1;
            m_byte_next = in_byte_reg;
        end
        m_run_last_next = (idx_reg == total_reg - 1'b1);
        m_out_last_next = m_run_last_next && in_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= '0;
            overflowed_reg <= 1'b0;
        end else if (cmd.plan) begin
            word_count_reg <= word_count_next;
            overflowed_reg <= overflowed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.plan && store_we) begin
            word_store_reg[word_count_reg[IDX_W-1:0]] <= in_byte_reg;
        end
        if (cmd.capture) begin
            in_byte_reg <= s_byte;
            in_last_reg <= s_last;
        end
        if (cmd.plan) begin
            src_repl_reg <= src_repl_next;
            src_n_reg    <= src_n_next;
            marker_reg   <= marker_next;
            total_reg    <= total_next;
            idx_reg      <= '0;
        end else if (cmd.load) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.load) begin
            m_byte_reg     <= m_byte_next;
            m_has_reg      <= m_has_next;
            m_run_last_reg <= m_run_last_next;
            m_out_last_reg <= m_out_last_next;
        end
    end

    assign status.plan_emits = (total_next != '0);
    assign status.item_final = m_run_last_next;
    assign m_byte     = m_byte_reg;
    assign m_has_byte = m_has_reg;
    assign m_run_last = m_run_last_reg;
    assign m_out_last = m_out_last_reg;

endmodule

>>> bench/tb_whole_word_replace.sv
`timescale 1ns / 1ps
// self-checking testbench for the whole-word replace stream block
module tb_whole_word_replace;
    import wwr_pkg::*;

    // quiet cycles before the run is declared hung: sender gap, block cycles
    // and nine results each behind a full receiver stall, taken many times over
    localparam int QUIET_LIMIT  = 2000;
    // settle time before a register write, covers the plan of an item still buffering
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 50;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } in_char_t;

    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       run_end;
        logic       str_end;
    } out_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    whole_word_replace dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),    // in_byte
        .s_tlast     (s_tlast),    // in_last
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),    // out_byte
        .m_tuser     (m_tuser),    // has_byte, run_last
        .m_tlast     (m_tlast)     // out_last
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // shadow of the configuration registers and the word buffer
    // ---------------------------------------------------------------
    logic        mc_r;
    logic [63:0] tgt_word_r;
    logic [3:0]  tgt_len_r;
    logic [63:0] rep_word_r;
    logic [3:0]  rep_len_r;

    logic [7:0]  word_buf [WORD_CAP];
    int          word_len = 0;
    logic        long_word = 1'b0;   // word ran past the buffer, passing through

    // results of the item being predicted
    logic [7:0]  run_chars [9];
    logic        run_has [9];
    int          run_n;

    in_char_t    pending_items [$];
    out_char_t   expected_chars [$];
    in_char_t    text_buf [$];
    logic [7:0]  word_chars [$];

    int items_queued = 0;   // items handed to the driver
    int in_sent = 0;        // items presented on the input
    int in_taken = 0;       // items accepted by the block
    int res_taken = 0;      // results accepted from the block
    int quiet_cycles = 0;
    int errors = 0;

    // queue append helpers
    task automatic add_expected(input out_char_t oc);
        expected_chars.insert(expected_chars.size(), oc);
    endtask

    task automatic add_pending(input logic [7:0] c, input logic l);
        in_char_t ic;
        ic.ch = c;
        ic.last = l;
        pending_items.insert(pending_items.size(), ic);
    endtask

    task automatic add_text(input logic [7:0] c, input logic l);
        in_char_t ic;
        ic.ch = c;
        ic.last = l;
        text_buf.insert(text_buf.size(), ic);
    endtask

    task automatic add_word_char(input logic [7:0] c);
        word_chars.insert(word_chars.size(), c);
    endtask

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic word_hits();
        logic [7:0] t;
        logic [7:0] w;
        if (tgt_len_r != word_len) return 1'b0;
        for (int i = 0; i < word_len; i++) begin
            t = tgt_word_r[8*i +: 8];
            w = word_buf[i];
            if (!mc_r) begin
                t = to_lower(t);
                w = to_lower(w);
            end
            if (t != w) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic emit_char(input logic [7:0] c, input logic h);
        if (run_n < 9) begin
            run_chars[run_n] = c;
            run_has[run_n] = h;
            run_n++;
        end
    endtask

    // a buffered word leaves either as the replacement or unchanged
    task automatic flush_word();
        int n;
        if (word_hits()) begin
            n = (rep_len_r > 4'd8) ? 8 : int'(rep_len_r);
            for (int i = 0; i < n; i++) emit_char(rep_word_r[8*i +: 8], 1'b1);
        end else begin
            for (int i = 0; i < word_len; i++) emit_char(word_buf[i], 1'b1);
        end
    endtask

    // works out the results of one accepted text item
    task automatic replace_step(input logic [7:0] c, input logic l);
        out_char_t oc;
        run_n = 0;
        if (c == DELIM_CHAR) begin
            if (!long_word) flush_word();
            // a space that ends the string is dropped
            if (!l) emit_char(DELIM_CHAR, 1'b1);
            word_len = 0;
            long_word = 1'b0;
        end else begin
            if (long_word) begin
                emit_char(c, 1'b1);
            end else if (word_len < WORD_CAP) begin
                word_buf[word_len] = c;
                word_len++;
            end else begin
                // buffer full: flush it as is together with this byte
                for (int i = 0; i < word_len; i++) emit_char(word_buf[i], 1'b1);
                emit_char(c, 1'b1);
                word_len = 0;
                long_word = 1'b1;
            end
            if (l) begin
                if (!long_word) flush_word();
                word_len = 0;
                long_word = 1'b0;
            end
        end
        // end of a string that produced nothing: one marker result
        if (l && run_n == 0) emit_char(8'd0, 1'b0);
        for (int k = 0; k < run_n; k++) begin
            oc.ch      = run_chars[k];
            oc.has     = run_has[k];
            oc.run_end = (k == run_n - 1);
            oc.str_end = (k == run_n - 1) && l;
            add_expected(oc);
        end
    endtask

    // ---------------------------------------------------------------
    // idle pattern: random waits between items, with bursts of none
    // ---------------------------------------------------------------
    task automatic draw_wait(inout int burst, output int w);
        if (burst > 0) begin
            burst--;
            w = 0;
        end else if ($urandom_range(0, 7) == 0) begin
            burst = $urandom_range(10, 40);
            w = 0;
        end else begin
            w = $urandom_range(0, 9);
        end
    endtask

    // input driver: presents queued items at the falling edge
    int tx_gap = 0;
    int tx_burst = 0;
    always @(negedge aclk) begin
        in_char_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken == in_sent) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_tdata  <= it.ch;
                s_tlast  <= it.last;
                s_tvalid <= 1'b1;
                in_sent++;
                draw_wait(tx_burst, tx_gap);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stalls a drawn number of cycles after each result
    int rx_wait = 0;
    int rx_burst = 0;
    int res_seen = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (res_taken != res_seen) begin
                res_seen = res_taken;
                draw_wait(rx_burst, rx_wait);
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: predicts on each accepted item, checks each accepted result
    always @(posedge aclk) begin
        logic in_fire;
        logic out_fire;
        out_char_t want;
        in_fire  = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (in_fire) begin
            replace_step(s_tdata, s_tlast);
            in_taken++;
        end
        if (out_fire) begin
            res_taken++;
            if (expected_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: byte %h has %b run_last %b last %b",
                         $time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.ch || m_tuser[0] !== want.has
                        || m_tuser[1] !== want.run_end || m_tlast !== want.str_end) begin
                    errors++;
                    $display({"%0t: mismatch: expected byte %h has %b run_last %b last %b,",
                              " got byte %h has %b run_last %b last %b"},
                             $time, want.ch, want.has, want.run_end, want.str_end,
                             m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                end
            end
        end
        if (aresetn) quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
    end

    // hang detection
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic set_reg(input cfg_index_t idx, input logic [63:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= v;
        case (idx)
            CFG_MATCH_CASE:   mc_r = v[0];
            CFG_TARGET_WORD:  tgt_word_r = v;
            CFG_TARGET_LEN:   tgt_len_r = v[3:0];
            CFG_REPLACE_WORD: rep_word_r = v;
            CFG_REPLACE_LEN:  rep_len_r = v[3:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // block idle: every item taken, every result back, and some slack for
    // items that were still buffering with no result
    task automatic wait_drained();
        while (in_taken != items_queued || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_byte(input logic [7:0] c, input logic l);
        add_pending(c, l);
        items_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [63:0] pack_word(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 254));
        if (c >= DELIM_CHAR) c = c + 8'd1;   // anything but a space
        return c;
    endfunction

    function automatic logic [7:0] letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = c ^ 8'h20;
        return c;
    endfunction

    // one random word into word_chars, near the target half of the time
    task automatic make_word();
        logic [7:0] c;
        int n;
        int pos;
        word_chars.delete();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // target copy, letters sometimes flipped in case
                for (int i = 0; i < tgt_len_r && i < 8; i++) begin
                    c = tgt_word_r[8*i +: 8];
                    if ($urandom_range(0, 3) == 0 && c != 8'd0) c = c ^ 8'h20;
                    add_word_char(c);
                end
            end
            4: begin
                // near miss: one byte changed
                for (int i = 0; i < tgt_len_r && i < 8; i++)
                    add_word_char(tgt_word_r[8*i +: 8]);
                if (word_chars.size() > 0) begin
                    pos = $urandom_range(0, word_chars.size() - 1);
                    word_chars[pos] = letter();
                end
            end
            5: begin
                n = $urandom_range(9, 13);
                for (int i = 0; i < n; i++) add_word_char(letter());
            end
            6: ;   // empty word
            7: begin
                for (int i = 0; i < 8; i++) add_word_char(any_char());
            end
            default: begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) add_word_char(letter());
            end
        endcase
    endtask

    // one random string: words split by spaces, or now and then plain noise
    task automatic queue_random_string();
        int n;
        text_buf.delete();
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                add_text(($urandom_range(0, 3) == 0) ? DELIM_CHAR : any_char(), 1'b0);
        end else begin
            n = $urandom_range(1, 5);
            for (int w = 0; w < n; w++) begin
                if (w > 0) add_text(DELIM_CHAR, 1'b0);
                make_word();
                foreach (word_chars[i]) add_text(word_chars[i], 1'b0);
            end
            // trailing space that must vanish
            if ($urandom_range(0, 3) == 0) add_text(DELIM_CHAR, 1'b0);
        end
        if (text_buf.size() == 0) add_text(letter(), 1'b0);
        text_buf[text_buf.size() - 1].last = 1'b1;
        foreach (text_buf[i]) queue_byte(text_buf[i].ch, text_buf[i].last);
    endtask

    // target of the given length, mostly letters, garbage above the length
    function automatic logic [63:0] make_target(input int n);
        logic [63:0] t;
        t = {$urandom, $urandom};
        for (int i = 0; i < n; i++)
            t[8*i +: 8] = ($urandom_range(0, 5) == 0) ? any_char() : letter();
        return t;
    endfunction

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    logic       ph_mc [6]  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [3:0] ph_tl [6]  = '{4'd8, 4'd0, 4'd3, 4'd1, 4'd8, 4'd5};
    logic [3:0] ph_rl [6]  = '{4'd0, 4'd8, 4'd2, 4'd8, 4'd5, 4'd3};

    initial begin
        int goal;
        // reset values of the shadow registers
        mc_r = 1'b1;
        tgt_word_r = '0;
        tgt_len_r = '0;
        rep_word_r = '0;
        rep_len_r = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty target, empty replacement
        queue_text(" ");        // lone space at the end: empty word vanishes, marker
        queue_text("a  b");     // empty word between two spaces
        queue_text("x ");       // trailing space dropped
        wait_drained();

        // case-insensitive match, bytes at the extremes, one overlong word
        set_reg(CFG_MATCH_CASE, 64'd0);
        set_reg(CFG_TARGET_WORD, pack_word("Cat"));
        set_reg(CFG_TARGET_LEN, 64'd3);
        set_reg(CFG_REPLACE_WORD, pack_word("dog"));
        set_reg(CFG_REPLACE_LEN, 64'd3);
        queue_text("cAT CAt");
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_text("abcdefghi");   // one byte over the buffer, ends in pass-through
        wait_drained();

        // random phases over several settings, extremes among them
        for (int p = 0; p < 6; p++) begin
            set_reg(CFG_MATCH_CASE, {63'd0, ph_mc[p]});
            set_reg(CFG_TARGET_WORD, make_target(ph_tl[p]));
            set_reg(CFG_TARGET_LEN, {60'd0, ph_tl[p]});
            set_reg(CFG_REPLACE_WORD, {$urandom, $urandom});
            set_reg(CFG_REPLACE_LEN, {60'd0, ph_rl[p]});
            goal = items_queued + PHASE_ITEMS;
            while (items_queued < goal) queue_random_string();
            wait_drained();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/wwr_pkg.sv
src/wwr_ctrl.sv
src/wwr_datapath.sv
src/whole_word_replace.sv
bench/tb_whole_word_replace.sv
